>>> rtl/wss_pkg.sv
// Package for the windowed sensor statistics core.
// Holds sizes, request and statistic codes, the entry layout and the controller states.
// Depends on nothing.
package wss_pkg;

    // Sizes of the statistics store
    localparam int SENSORS      = 8;
    localparam int VALUE_BITS   = 16;
    localparam int COUNT_BITS   = 24;
    localparam int SUM_BITS     = 40;
    localparam int FRAC_BITS    = 8;
    localparam int WIN_NUM      = 4;
    localparam int ENTRIES      = SENSORS * WIN_NUM;
    localparam int ADDR_BITS    = $clog2(ENTRIES);
    localparam int LS_IDX_BITS  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SIDX_CMP     = 8;
    localparam int QUO_BITS     = SUM_BITS + FRAC_BITS;
    localparam int DCNT_BITS    = $clog2(QUO_BITS);

    // Port widths fixed by the request and result layout
    localparam int REQ_BITS     = 2;
    localparam int SIDX_BITS    = 3;
    localparam int SAMPLE_BITS  = 16;
    localparam int WIN_BITS     = 2;
    localparam int KIND_BITS    = 2;

    // Request type codes
    localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd2;

    // Window codes
    localparam logic [WIN_BITS-1:0] WIN_MINUTE = 2'd0;
    localparam logic [WIN_BITS-1:0] WIN_HOUR   = 2'd1;
    localparam logic [WIN_BITS-1:0] WIN_DAY    = 2'd2;
    localparam logic [WIN_BITS-1:0] WIN_REAL   = 2'd3;

    // Statistic codes
    localparam logic [KIND_BITS-1:0] STAT_AVG = 2'd0;
    localparam logic [KIND_BITS-1:0] STAT_MIN = 2'd1;
    localparam logic [KIND_BITS-1:0] STAT_MAX = 2'd2;
    localparam logic [KIND_BITS-1:0] STAT_SUM = 2'd3;

    // One window of one sensor
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_BITS-1:0] vmin;
        logic [VALUE_BITS-1:0] vmax;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_QRY_RD,
        ST_QRY_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

>>> rtl/windowed_sensor_statistics_core.sv
// Windowed sensor statistics core: per-sensor minute/hour/day/real windows.
// Keeps the windows in one synchronous entry memory; average via a bit-serial divider.
// Depends on wss_pkg.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         i_req_valid / o_req_ready     type, sensor, sample, window, kind
//   result    out        o_res_valid / i_res_ready     value, from-last flag, average flag
//
// Add: a read and a write-back of each of the four window entries in turn.
// Clear: the entry valid bits of the chosen levels drop at once.
// Query: read and evaluate; an average adds the one-bit-per-cycle divider.
// Reset clears the valid bits and last samples at once; no clearing pass.
// A finished result waits in the output register; the next request is taken meanwhile,
// and only a second result stalls until the first has been taken.
module windowed_sensor_statistics_core
    import wss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  logic [REQ_BITS-1:0]    i_req_type,
    input  logic [SIDX_BITS-1:0]   i_sensor_index,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [WIN_BITS-1:0]    i_window,
    input  logic [KIND_BITS-1:0]   i_stat_kind,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output logic [SUM_BITS-1:0]    o_result_value,
    output logic                   o_from_last_value,
    output logic                   o_is_average
);

    t_state r_state, n_state;

    // Captured request
    logic [SIDX_BITS-1:0]  r_sensor;
    logic                  r_sensor_ok;
    logic [VALUE_BITS-1:0] r_value;
    logic [WIN_BITS-1:0]   r_win;
    logic [KIND_BITS-1:0]  r_kind;

    // Entry memory and its valid bits
    logic [$bits(t_entry)-1:0] r_mem [ENTRIES];
    logic [$bits(t_entry)-1:0] r_rd_data;
    logic                      r_rd_valid;
    logic [ENTRIES-1:0]        r_entry_valid;
    logic [VALUE_BITS-1:0]     r_last [SENSORS];

    // Divider
    logic [QUO_BITS-1:0]   r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [DCNT_BITS-1:0]  r_div_cnt;

    // Staged and output result
    logic [SUM_BITS-1:0] r_res_value;
    logic                r_res_last;
    logic                r_res_avg;
    logic                r_out_valid;
    logic [SUM_BITS-1:0] r_out_value;
    logic                r_out_last;
    logic                r_out_avg;

    // Control decoded from the state
    logic req_ready;
    logic rd_en;
    logic wr_en;
    logic eval_en;
    logic div_en;
    logic load_out;

    logic                   accept;
    logic                   in_sensor_ok;
    logic [ADDR_BITS-1:0]   addr;
    t_entry                 entry;
    t_entry                 n_entry;
    logic [SUM_BITS:0]      sum_ext;
    logic [KIND_BITS-1:0]   eff_kind;
    logic                   need_div;
    logic [VALUE_BITS-1:0]  last_val;
    logic [COUNT_BITS:0]    rem_shift;
    logic                   rem_ge;
    logic [QUO_BITS-1:0]    quo_next;
    logic                   slot_free;

    assign accept       = i_req_valid && req_ready;
    assign in_sensor_ok = SIDX_CMP'(i_sensor_index) < SIDX_CMP'(SENSORS);
    assign addr         = ADDR_BITS'({r_sensor, r_win});
    assign entry        = r_rd_valid ? t_entry'(r_rd_data) : '0;
    assign eff_kind     = (r_win == WIN_REAL) ? STAT_AVG : r_kind;
    assign need_div     = r_sensor_ok && (entry.count != '0) && (eff_kind == STAT_AVG);
    assign last_val     = r_last[LS_IDX_BITS'(r_sensor)];
    assign slot_free    = !r_out_valid || i_res_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_req_type == REQ_ADD && in_sensor_ok) begin
                        n_state = ST_ADD_RD;
                    end else if (i_req_type == REQ_QUERY) begin
                        n_state = ST_QRY_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ADD_RD:   n_state = ST_ADD_WR;
            ST_ADD_WR:   n_state = (r_win == WIN_REAL) ? ST_IDLE : ST_ADD_RD;
            ST_QRY_RD:   n_state = ST_QRY_EVAL;
            ST_QRY_EVAL: n_state = need_div ? ST_DIV : ST_DONE;
            ST_DIV:      n_state = (r_div_cnt == DCNT_BITS'(QUO_BITS - 1)) ? ST_DONE : ST_DIV;
            ST_DONE:     n_state = slot_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        eval_en   = 1'b0;
        div_en    = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE:     req_ready = 1'b1;
            ST_ADD_RD:   rd_en     = 1'b1;
            ST_ADD_WR:   wr_en     = 1'b1;
            ST_QRY_RD:   rd_en     = 1'b1;
            ST_QRY_EVAL: eval_en   = 1'b1;
            ST_DIV:      div_en    = 1'b1;
            ST_DONE:     load_out  = slot_free;
            default:     req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request; step the window during an add
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sensor    <= i_sensor_index;
            r_sensor_ok <= in_sensor_ok;
            r_value     <= VALUE_BITS'(i_sample_value);
            r_kind      <= i_stat_kind;
            r_win       <= (i_req_type == REQ_ADD) ? WIN_MINUTE : i_window;
        end else if (wr_en) begin
            r_win <= r_win + WIN_BITS'(1);
        end
    end

    // Fold the sample into the entry just read
    always_comb begin
        sum_ext = {1'b0, entry.sum} + (SUM_BITS + 1)'(r_value);
        n_entry = entry;
        if (entry.count == '0) begin
            n_entry.vmin = r_value;
            n_entry.vmax = r_value;
        end else begin
            if (r_value < entry.vmin) n_entry.vmin = r_value;
            if (r_value > entry.vmax) n_entry.vmax = r_value;
        end
        n_entry.sum = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        if (entry.count != '1) n_entry.count = entry.count + COUNT_BITS'(1);
    end

    // Entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= n_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // Valid bits: set on write-back, drop on clear of a level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_valid <= r_entry_valid[addr];
            end
            if (wr_en) begin
                r_entry_valid[addr] <= 1'b1;
            end
            if (accept && i_req_type == REQ_CLEAR && i_window != WIN_REAL) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    if (WIN_BITS'(e) <= i_window) begin
                        r_entry_valid[ADDR_BITS'(e)] <= 1'b0;
                    end
                end
            end
        end
    end

    // Last sample of each sensor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_last[LS_IDX_BITS'(s)] <= '0;
            end
        end else if (accept && i_req_type == REQ_ADD && in_sensor_ok) begin
            r_last[LS_IDX_BITS'(i_sensor_index)] <= VALUE_BITS'(i_sample_value);
        end
    end

    // One restoring division step: shift in a dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {r_rem, r_quo[QUO_BITS-1]};
        rem_ge    = rem_shift >= {1'b0, r_den};
        quo_next  = {r_quo[QUO_BITS-2:0], rem_ge};
    end

    // Divider and staged result
    always_ff @(posedge i_clk) begin
        if (eval_en) begin
            r_quo      <= {entry.sum, FRAC_BITS'(0)};
            r_rem      <= '0;
            r_den      <= entry.count;
            r_div_cnt  <= '0;
            if (!r_sensor_ok) begin
                r_res_value <= '0;
                r_res_last  <= 1'b0;
                r_res_avg   <= 1'b0;
            end else if (entry.count == '0) begin
                r_res_value <= SUM_BITS'(last_val);
                r_res_last  <= 1'b1;
                r_res_avg   <= 1'b0;
            end else begin
                r_res_last <= 1'b0;
                r_res_avg  <= (eff_kind == STAT_AVG);
                unique case (eff_kind)
                    STAT_AVG: r_res_value <= '0;
                    STAT_MIN: r_res_value <= SUM_BITS'(entry.vmin);
                    STAT_MAX: r_res_value <= SUM_BITS'(entry.vmax);
                    STAT_SUM: r_res_value <= entry.sum;
                    default:  r_res_value <= '0;
                endcase
            end
        end else if (div_en) begin
            r_quo     <= quo_next;
            r_rem     <= rem_ge ? COUNT_BITS'(rem_shift - {1'b0, r_den})
                                : rem_shift[COUNT_BITS-1:0];
            r_div_cnt <= r_div_cnt + DCNT_BITS'(1);
            // Clamp the finished quotient to the result width
            if (r_div_cnt == DCNT_BITS'(QUO_BITS - 1)) begin
                r_res_value <= (quo_next[QUO_BITS-1:SUM_BITS] != '0) ? '1
                                                                     : quo_next[SUM_BITS-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= r_res_value;
            r_out_last  <= r_res_last;
            r_out_avg   <= r_res_avg;
        end
    end

    assign o_req_ready       = req_ready;
    assign o_res_valid       = r_out_valid;
    assign o_result_value    = r_out_value;
    assign o_from_last_value = r_out_last;
    assign o_is_average      = r_out_avg;

endmodule

>>> tb/wss_stats_checker.sv
// Checker for the windowed sensor statistics core: watches both channels,
// keeps its own copy of the window store and compares every query result.
// Depends on wss_pkg.
module wss_stats_checker
    import wss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [REQ_BITS-1:0]    i_req_type,
    input  logic [SIDX_BITS-1:0]   i_sensor_index,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [WIN_BITS-1:0]    i_window,
    input  logic [KIND_BITS-1:0]   i_stat_kind,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [SUM_BITS-1:0]    i_result_value,
    input  logic                   i_from_last_value,
    input  logic                   i_is_average,
    output int                     o_fail_count,
    output int                     o_outstanding,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SUM_BITS-1:0]   SUM_MAX     = '1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
    localparam int                    MAX_REPORTS = 10;

    typedef struct packed {
        logic [SUM_BITS-1:0] value;
        logic                from_last;
        logic                is_avg;
    } t_stat_result;

    // Shadow copy of the window store
    logic [SUM_BITS-1:0]   stat_sum [ENTRIES];
    logic [COUNT_BITS-1:0] stat_cnt [ENTRIES];
    logic [VALUE_BITS-1:0] stat_lo  [ENTRIES];
    logic [VALUE_BITS-1:0] stat_hi  [ENTRIES];
    logic [VALUE_BITS-1:0] last_val [SENSORS];

    t_stat_result pending_stats [$];
    int           fail_count;
    int           checked;

    // Empty one window level of every sensor
    task automatic wipe_level(input int lvl);
        logic [ADDR_BITS-1:0] k;
        for (int s = 0; s < SENSORS; s++) begin
            k = ADDR_BITS'(s * WIN_NUM + lvl);
            stat_sum[k] = '0;
            stat_cnt[k] = '0;
            stat_lo[k]  = '0;
            stat_hi[k]  = '0;
        end
    endtask

    // Work out the statistic a query should return from the current store
    function automatic t_stat_result query_stat(input logic [SIDX_BITS-1:0] sidx,
                                                input logic [WIN_BITS-1:0]  win,
                                                input logic [KIND_BITS-1:0] kind);
        t_stat_result         r;
        logic [ADDR_BITS-1:0] k;
        logic [QUO_BITS-1:0]  quo;
        r = '0;
        if (SIDX_CMP'(sidx) < SIDX_CMP'(SENSORS)) begin
            k = ADDR_BITS'(int'(sidx) * WIN_NUM + int'(win));
            // the real window reports its mean whatever kind is asked
            if (win == WIN_REAL) kind = STAT_AVG;
            if (stat_cnt[k] == '0) begin
                r.value     = SUM_BITS'(last_val[sidx]);
                r.from_last = 1'b1;
            end else begin
                case (kind)
                    STAT_AVG: begin
                        quo      = {stat_sum[k], {FRAC_BITS{1'b0}}} / QUO_BITS'(stat_cnt[k]);
                        r.value  = (quo > QUO_BITS'(SUM_MAX)) ? SUM_MAX : quo[SUM_BITS-1:0];
                        r.is_avg = 1'b1;
                    end
                    STAT_MIN: r.value = SUM_BITS'(stat_lo[k]);
                    STAT_MAX: r.value = SUM_BITS'(stat_hi[k]);
                    default:  r.value = stat_sum[k];
                endcase
            end
        end
        return r;
    endfunction

    // Apply an accepted request to the shadow store; queue the result of a query
    task automatic track_request();
        logic [VALUE_BITS-1:0] v;
        logic [ADDR_BITS-1:0]  k;
        v = i_sample_value[VALUE_BITS-1:0];
        case (i_req_type)
            REQ_ADD: begin
                if (SIDX_CMP'(i_sensor_index) < SIDX_CMP'(SENSORS)) begin
                    last_val[i_sensor_index] = v;
                    for (int w = 0; w < WIN_NUM; w++) begin
                        k = ADDR_BITS'(int'(i_sensor_index) * WIN_NUM + w);
                        // first sample seeds the extremes
                        if (stat_cnt[k] == '0) begin
                            stat_lo[k] = v;
                            stat_hi[k] = v;
                        end else begin
                            if (v < stat_lo[k]) stat_lo[k] = v;
                            if (v > stat_hi[k]) stat_hi[k] = v;
                        end
                        stat_sum[k] = (SUM_MAX - stat_sum[k] < SUM_BITS'(v)) ?
                                      SUM_MAX : stat_sum[k] + SUM_BITS'(v);
                        if (stat_cnt[k] != CNT_MAX) stat_cnt[k] = stat_cnt[k] + COUNT_BITS'(1);
                    end
                end
            end
            REQ_CLEAR: begin
                // the real window survives every clear
                if (i_window != WIN_REAL) begin
                    for (int lvl = 0; lvl <= int'(i_window); lvl++) wipe_level(lvl);
                end
            end
            REQ_QUERY: begin
                pending_stats.push_back(query_stat(i_sensor_index, i_window, i_stat_kind));
            end
            default: ;
        endcase
    endtask

    // Compare a delivered result with the oldest outstanding query
    task automatic check_result();
        t_stat_result want;
        if (pending_stats.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: value %h from_last %b avg %b",
                         i_result_value, i_from_last_value, i_is_average);
        end else begin
            want = pending_stats.pop_front();
            checked++;
            if (want.value !== i_result_value || want.from_last !== i_from_last_value ||
                want.is_avg !== i_is_average) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d: expected %h from_last %b avg %b, got %h %b %b",
                             checked, want.value, want.from_last, want.is_avg,
                             i_result_value, i_from_last_value, i_is_average);
            end
        end
    endtask

    // Results are handled before requests: a query never completes at its own edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int lvl = 0; lvl < WIN_NUM; lvl++) wipe_level(lvl);
            for (int s = 0; s < SENSORS; s++) last_val[LS_IDX_BITS'(s)] = '0;
            pending_stats.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_req_valid && i_req_ready) track_request();
        end
        o_fail_count  <= fail_count;
        o_outstanding <= pending_stats.size();
        o_checked     <= checked;
    end

endmodule

>>> tb/tb_top.sv
// Top of the windowed sensor statistics testbench: clock, reset, request stimulus
// and result back-pressure, with the checker beside the core and the final verdict.
// Depends on wss_pkg, windowed_sensor_statistics_core and wss_stats_checker.
module tb_top
    import wss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED   = 2'd3;
    localparam int                  RANDOM_ITEMS = 1800;
    localparam int                  CYCLE_LIMIT  = 600000;
    localparam int                  DRAIN_CYCLES = 64;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_req_valid    = 1'b0;
    logic                   o_req_ready;
    logic [REQ_BITS-1:0]    i_req_type     = '0;
    logic [SIDX_BITS-1:0]   i_sensor_index = '0;
    logic [SAMPLE_BITS-1:0] i_sample_value = '0;
    logic [WIN_BITS-1:0]    i_window       = '0;
    logic [KIND_BITS-1:0]   i_stat_kind    = '0;
    logic                   o_res_valid;
    logic                   i_res_ready    = 1'b0;
    logic [SUM_BITS-1:0]    o_result_value;
    logic                   o_from_last_value;
    logic                   o_is_average;

    int          fail_count;
    int          outstanding;
    int          checked;
    logic        quiet = 1'b0;
    int          stall_left;
    int unsigned cycle_count;
    int          n_add, n_clear, n_query, n_unused;

    windowed_sensor_statistics_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_req_type        (i_req_type),
        .i_sensor_index    (i_sensor_index),
        .i_sample_value    (i_sample_value),
        .i_window          (i_window),
        .i_stat_kind       (i_stat_kind),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_result_value    (o_result_value),
        .o_from_last_value (o_from_last_value),
        .o_is_average      (o_is_average)
    );

    wss_stats_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .i_req_ready       (o_req_ready),
        .i_req_type        (i_req_type),
        .i_sensor_index    (i_sensor_index),
        .i_sample_value    (i_sample_value),
        .i_window          (i_window),
        .i_stat_kind       (i_stat_kind),
        .i_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .i_result_value    (o_result_value),
        .i_from_last_value (o_from_last_value),
        .i_is_average      (o_is_average),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_checked         (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side in short bursts, about six percent of the time, none while quiet
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_res_ready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < 2) begin
            stall_left  <= $urandom_range(4);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    // Present one request, possibly after an idle gap, and hold it until taken
    task automatic send_req(input logic [REQ_BITS-1:0]    rtype,
                            input logic [SIDX_BITS-1:0]   sidx,
                            input logic [SAMPLE_BITS-1:0] val,
                            input logic [WIN_BITS-1:0]    win,
                            input logic [KIND_BITS-1:0]   kind);
        int gap;
        if (!quiet && $urandom_range(99) < 15) begin
            // mostly short gaps, now and then one that spans a whole division
            gap = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid    <= 1'b1;
        i_req_type     <= rtype;
        i_sensor_index <= sidx;
        i_sample_value <= val;
        i_window       <= win;
        i_stat_kind    <= kind;
        do @(posedge i_clk); while (!o_req_ready);
        case (rtype)
            REQ_ADD:   n_add++;
            REQ_CLEAR: n_clear++;
            REQ_QUERY: n_query++;
            default:   n_unused++;
        endcase
    endtask

    initial begin
        int                     sent;
        int                     pick;
        logic [REQ_BITS-1:0]    rtype;
        logic [SAMPLE_BITS-1:0] val;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, extremes, every statistic, every clear level
        send_req(REQ_QUERY, 0, 16'h0000, WIN_MINUTE, STAT_AVG);
        send_req(REQ_QUERY, 7, 16'hFFFF, WIN_REAL,   STAT_SUM);
        send_req(REQ_ADD,   0, 16'h0000, WIN_MINUTE, STAT_AVG);
        send_req(REQ_ADD,   0, 16'hFFFF, WIN_DAY,    STAT_SUM);
        send_req(REQ_ADD,   7, 16'hFFFF, WIN_REAL,   STAT_MAX);
        send_req(REQ_ADD,   7, 16'h3039, WIN_HOUR,   STAT_MIN);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_MINUTE, STAT_AVG);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_HOUR,   STAT_MIN);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_DAY,    STAT_MAX);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_MINUTE, STAT_SUM);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_REAL,   STAT_MAX);
        send_req(REQ_UNUSED, 0, 16'hFFFF, WIN_MINUTE, STAT_SUM);
        send_req(REQ_CLEAR, 3, 16'h0000, WIN_MINUTE, STAT_AVG);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_MINUTE, STAT_MIN);
        send_req(REQ_QUERY, 0, 16'h0000, WIN_HOUR,   STAT_AVG);
        send_req(REQ_CLEAR, 5, 16'h0000, WIN_HOUR,   STAT_AVG);
        send_req(REQ_QUERY, 7, 16'h0000, WIN_HOUR,   STAT_MAX);
        send_req(REQ_QUERY, 7, 16'h0000, WIN_DAY,    STAT_SUM);
        send_req(REQ_CLEAR, 2, 16'h0000, WIN_DAY,    STAT_AVG);
        send_req(REQ_QUERY, 7, 16'h0000, WIN_DAY,    STAT_AVG);
        send_req(REQ_QUERY, 7, 16'h0000, WIN_REAL,   STAT_MIN);
        send_req(REQ_CLEAR, 1, 16'h0000, WIN_REAL,   STAT_AVG);
        send_req(REQ_ADD,   3, 16'h0001, WIN_MINUTE, STAT_AVG);
        send_req(REQ_QUERY, 3, 16'h0000, WIN_MINUTE, STAT_AVG);
        send_req(REQ_QUERY, 7, 16'h0000, WIN_REAL,   STAT_AVG);

        // Random: mostly samples and queries, occasional clears and unused codes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet <= (sent >= 700 && sent < 1000);
            pick = $urandom_range(99);
            if (pick < 2)       rtype = REQ_UNUSED;
            else if (pick < 52) rtype = REQ_ADD;
            else if (pick < 56) rtype = REQ_CLEAR;
            else                rtype = REQ_QUERY;
            case ($urandom_range(9))
                0:       val = '0;
                1:       val = '1;
                default: val = SAMPLE_BITS'($urandom);
            endcase
            send_req(rtype, SIDX_BITS'($urandom_range(7)), val,
                     WIN_BITS'($urandom_range(3)), KIND_BITS'($urandom_range(3)));
            if (rtype != REQ_UNUSED) sent++;
        end

        // Drop valid and drain the outstanding queries
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d samples, %0d clears, %0d queries and %0d unused request codes",
                 n_add, n_clear, n_query, n_unused);
        $display("compared %0d query results, %0d failures", checked, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> windowed_sensor_statistics_core.f
rtl/wss_pkg.sv
rtl/windowed_sensor_statistics_core.sv
tb/wss_stats_checker.sv
tb/tb_top.sv
